[hw/rtl/fcw_pkg.sv]
// Shared types and constants of the FAT12 cluster chain walker.
package fcw_pkg;

  localparam int ENTRY_W   = 12;
  localparam int CLUSTER_W = 12;
  localparam int SIZE_W    = 32;
  localparam int OFFSET_W  = 32;
  localparam int COUNT_W   = 20;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  // Command codes on the input channel.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CONT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_CHAIN  = 2'd1;
  localparam logic [1:0] ST_LOW_START = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_RSV_SECT   = 3'd0;
  localparam logic [2:0] REG_BYTES_SECT = 3'd1;
  localparam logic [2:0] REG_SECT_CLUS  = 3'd2;
  localparam logic [2:0] REG_FAT_COPIES = 3'd3;
  localparam logic [2:0] REG_FAT_SECT   = 3'd4;
  localparam logic [2:0] REG_ROOT_ENT   = 3'd5;

  localparam logic [ENTRY_W-1:0] ENT_RESERVED_LO = 12'hFF7;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 20'hFFFFF;

  typedef enum logic [1:0] {
    K_LOAD      = 2'd0,
    K_START     = 2'd1,
    K_CONT      = 2'd2,
    K_BAD_START = 2'd3
  } fcw_kind_t;

  typedef struct packed {
    fcw_kind_t              kind;
    logic [7:0]             fat_byte;
    logic [CLUSTER_W-1:0]   cluster;
    logic [SIZE_W-1:0]      size;
  } fcw_item_t;

  typedef struct packed {
    logic [15:0] reserved_sectors;
    logic [12:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [2:0]  fat_copies;
    logic [15:0] fat_sectors;
    logic [15:0] root_entry_count;
  } fcw_cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0]  byte_offset;
    logic [COUNT_W-1:0]   byte_count;
    logic [CLUSTER_W-1:0] cluster;
    logic                 last;
    logic [1:0]           status;
  } fcw_result_t;

endpackage

[hw/rtl/fcw_regs.sv]
// Geometry register file behind the APB-style configuration port.
module fcw_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcw_pkg::CFG_AW-1:0] paddr,
  input  logic [fcw_pkg::CFG_DW-1:0] pwdata,
  output logic [fcw_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output fcw_pkg::fcw_cfg_t         cfg
);
  import fcw_pkg::*;

  fcw_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reserved_sectors    <= 16'd1;
      cfg_r.bytes_per_sector    <= 13'd512;
      cfg_r.sectors_per_cluster <= 8'd1;
      cfg_r.fat_copies          <= 3'd2;
      cfg_r.fat_sectors         <= 16'd9;
      cfg_r.root_entry_count    <= 16'd224;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RSV_SECT:   cfg_r.reserved_sectors    <= pwdata[15:0];
        REG_BYTES_SECT: cfg_r.bytes_per_sector    <= pwdata[12:0];
        REG_SECT_CLUS:  cfg_r.sectors_per_cluster <= pwdata[7:0];
        REG_FAT_COPIES: cfg_r.fat_copies          <= pwdata[2:0];
        REG_FAT_SECT:   cfg_r.fat_sectors         <= pwdata[15:0];
        REG_ROOT_ENT:   cfg_r.root_entry_count    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RSV_SECT:   prdata = {16'd0, cfg_r.reserved_sectors};
      REG_BYTES_SECT: prdata = {19'd0, cfg_r.bytes_per_sector};
      REG_SECT_CLUS:  prdata = {24'd0, cfg_r.sectors_per_cluster};
      REG_FAT_COPIES: prdata = {29'd0, cfg_r.fat_copies};
      REG_FAT_SECT:   prdata = {16'd0, cfg_r.fat_sectors};
      REG_ROOT_ENT:   prdata = {16'd0, cfg_r.root_entry_count};
      default:        prdata = '0;
    endcase
  end

endmodule

[hw/rtl/fcw_front.sv]
// Command intake: decodes each item into a kind and queues it for the back end.
module fcw_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_fat_byte,
  input  logic [fcw_pkg::CLUSTER_W-1:0] in_start_cluster,
  input  logic [fcw_pkg::SIZE_W-1:0]    in_file_size,
  output logic                          busy,
  input  logic                          pop,
  output logic                          head_valid,
  output fcw_pkg::fcw_item_t            head
);
  import fcw_pkg::*;

  fcw_item_t      q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           accept;
  logic           push;
  logic           do_pop;
  fcw_item_t      item;

  assign busy       = (cnt_r == QCW'(QDEPTH));
  assign accept     = start && !busy;
  assign push       = accept && (in_command != CMD_NOP);
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // A start naming cluster 0 or 1 is flagged here so the back end only reports it.
  always_comb begin
    item.fat_byte = in_fat_byte;
    item.cluster  = in_start_cluster;
    item.size     = in_file_size;
    case (in_command)
      CMD_LOAD:  item.kind = K_LOAD;
      CMD_START: item.kind = (in_start_cluster < CLUSTER_W'(2)) ? K_BAD_START : K_START;
      CMD_CONT:  item.kind = K_CONT;
      default:   item.kind = K_LOAD;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> cnt_r == $past(cnt_r) + QCW'(1))
    else $error("queued item not counted");

  a_nop_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_NOP |=> cnt_r <= $past(cnt_r))
    else $error("unknown command entered the queue");
`endif

endmodule

[hw/rtl/fcw_back.sv]
// Execution side: FAT table unpack and storage, chain stepping and offset arithmetic.
module fcw_back #(
  parameter int FAT_ENTRIES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcw_pkg::fcw_cfg_t    cfg,
  input  logic                 head_valid,
  input  fcw_pkg::fcw_item_t   head,
  output logic                 pop,
  output logic                 res_valid,
  output fcw_pkg::fcw_result_t res
);
  import fcw_pkg::*;

  localparam int AW  = $clog2(FAT_ENTRIES);
  localparam int LIW = $clog2(FAT_ENTRIES + 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;

  // Table storage and its unpack state.
  logic [ENTRY_W-1:0] table_mem [FAT_ENTRIES];
  logic [ENTRY_W-1:0] rdata_r;
  logic               tbl_we, tbl_re;
  logic [ENTRY_W-1:0] tbl_wd;
  logic [AW-1:0]      tbl_ra;
  logic [1:0]         phase_r, phase_nxt;
  logic [ENTRY_W-1:0] partial_r, partial_nxt;
  logic [LIW-1:0]     load_idx_r, load_idx_nxt;

  // Chain state.
  logic [CLUSTER_W-1:0] cur_r, cur_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic                 active_r, active_nxt;

  // Arithmetic pipeline registers.
  logic                 oob_r, oob_nxt;
  logic [19:0]          base1_r;
  logic [20:0]          clb_r;
  logic [32:0]          base2_r;
  logic signed [35:0]   rel_r;
  logic [COUNT_W-1:0]   take_r;
  logic [ENTRY_W-1:0]   next_r;

  logic [CLUSTER_W-1:0] rd_cl;
  logic [18:0]          fcfs;
  logic signed [13:0]   cl_m2;
  logic signed [21:0]   clb_s;
  logic [SIZE_W-1:0]    small_take;
  logic signed [35:0]   off_sum;
  logic [OFFSET_W-1:0]  off_sat;
  logic [SIZE_W-1:0]    rem_after;
  logic                 chain_end;

  logic                 res_valid_r, res_valid_nxt;
  fcw_result_t          res_r, res_nxt;

  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign rd_cl  = (head.kind == K_START) ? head.cluster : cur_r;
  assign tbl_ra = rd_cl[AW-1:0];
  assign fcfs   = cfg.fat_copies * cfg.fat_sectors;
  assign cl_m2  = $signed({2'b00, cur_r}) - 14'sd2;
  assign clb_s  = $signed({1'b0, clb_r});

  // Take min(remaining, cluster bytes), then cap at the byte count field.
  assign small_take = (rem_r < SIZE_W'(clb_r)) ? rem_r : SIZE_W'(clb_r);

  // Offset = data start + (cluster - 2) * cluster bytes, clamped to 32 bits.
  assign off_sum = $signed({3'b000, base2_r})
                 + $signed({15'd0, cfg.root_entry_count, 5'd0})
                 + rel_r;
  assign off_sat = off_sum[35] ? '0 :
                   (|off_sum[34:32]) ? '1 : off_sum[31:0];
  assign rem_after = rem_r - SIZE_W'(take_r);
  assign chain_end = (next_r == '0) || (next_r >= ENT_RESERVED_LO) || (rem_after == '0);

  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    tbl_wd        = '0;
    phase_nxt     = phase_r;
    partial_nxt   = partial_r;
    load_idx_nxt  = load_idx_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    active_nxt    = active_r;
    oob_nxt       = oob_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    case (state_r)
      B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.kind)
            K_LOAD: begin
              case (phase_r)
                2'd0: begin
                  partial_nxt = {4'd0, head.fat_byte};
                  phase_nxt   = 2'd1;
                end
                2'd1: begin
                  tbl_we      = 1'b1;
                  tbl_wd      = {head.fat_byte[3:0], partial_r[7:0]};
                  partial_nxt = {8'd0, head.fat_byte[7:4]};
                  phase_nxt   = 2'd2;
                end
                default: begin
                  tbl_we      = 1'b1;
                  tbl_wd      = {head.fat_byte, partial_r[3:0]};
                  partial_nxt = '0;
                  phase_nxt   = 2'd0;
                end
              endcase
              // Once the table is full the phase still cycles but nothing is stored.
              if (tbl_we && (load_idx_r < LIW'(FAT_ENTRIES))) begin
                load_idx_nxt = load_idx_r + LIW'(1);
              end else begin
                tbl_we = 1'b0;
              end
            end
            K_BAD_START: begin
              res_valid_nxt = 1'b1;
              res_nxt       = '{byte_offset: '0, byte_count: '0, cluster: '0,
                                last: 1'b0, status: ST_LOW_START};
              active_nxt    = 1'b0;
            end
            K_START: begin
              cur_nxt   = head.cluster;
              rem_nxt   = head.size;
              tbl_re    = 1'b1;
              oob_nxt   = (32'(rd_cl) >= FAT_ENTRIES);
              state_nxt = B_MUL;
            end
            default: begin
              if (!active_r) begin
                res_valid_nxt = 1'b1;
                res_nxt       = '{byte_offset: '0, byte_count: '0, cluster: '0,
                                  last: 1'b0, status: ST_NO_CHAIN};
              end else begin
                tbl_re    = 1'b1;
                oob_nxt   = (32'(rd_cl) >= FAT_ENTRIES);
                state_nxt = B_MUL;
              end
            end
          endcase
        end
      end
      B_MUL: begin
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        res_valid_nxt = 1'b1;
        res_nxt       = '{byte_offset: off_sat, byte_count: take_r, cluster: cur_r,
                          last: chain_end, status: ST_OK};
        rem_nxt       = rem_after;
        active_nxt    = !chain_end;
        if (!chain_end) begin
          cur_nxt = next_r;
        end
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      phase_r     <= '0;
      partial_r   <= '0;
      load_idx_r  <= '0;
      cur_r       <= '0;
      rem_r       <= '0;
      active_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      partial_r   <= partial_nxt;
      load_idx_r  <= load_idx_nxt;
      cur_r       <= cur_nxt;
      rem_r       <= rem_nxt;
      active_r    <= active_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload and arithmetic registers, no reset.
  always_ff @(posedge clk) begin
    oob_r   <= oob_nxt;
    res_r   <= res_nxt;
    base1_r <= {4'd0, cfg.reserved_sectors} + 20'(fcfs);
    clb_r   <= cfg.sectors_per_cluster * cfg.bytes_per_sector;
    if (state_r == B_MUL) begin
      next_r  <= oob_r ? '0 : rdata_r;
      base2_r <= base1_r * cfg.bytes_per_sector;
      rel_r   <= cl_m2 * clb_s;
      take_r  <= (small_take > SIZE_W'(COUNT_MAX)) ? COUNT_MAX : small_take[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[load_idx_r[AW-1:0]] <= tbl_wd;
    end
    if (tbl_re) begin
      rdata_r <= table_mem[tbl_ra];
    end
  end

`ifndef SYNTHESIS
  a_ok_not_last_keeps_chain: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.status == ST_OK && !res_r.last |-> active_r)
    else $error("chain dropped although result was not last");

  a_error_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.status != ST_OK |->
      !active_r && res_r.byte_count == '0 && res_r.cluster == '0 && !res_r.last)
    else $error("error result carries data or leaves chain active");

  a_ok_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.status == ST_OK |-> $past(state_r) == B_EMIT)
    else $error("cluster result issued outside the emit step");
`endif

endmodule

[hw/rtl/fat12_cluster_chain_walker_unit.sv]
// Result path: a start or continue result is formed by the table read, the multiply state
// and the emit state, then registered; an error result is registered from the queue head; a
// load item gives no result. Throughput: one FAT byte per cycle while the back end is idle;
// a chain step holds the back end in its multiply and emit states before the next pop.
// Reset: synchronous active-low rst_n clears queue, sequencer, unpack and chain state and
// reloads geometry defaults; table contents are not cleared. Results cannot be stalled.
module fat12_cluster_chain_walker_unit #(
  parameter int FAT_ENTRIES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_fat_byte,
  input  logic [fcw_pkg::CLUSTER_W-1:0] in_start_cluster,
  input  logic [fcw_pkg::SIZE_W-1:0]    in_file_size,
  // Result channel.
  output logic                          out_valid,
  output logic [fcw_pkg::OFFSET_W-1:0]  out_byte_offset,
  output logic [fcw_pkg::COUNT_W-1:0]   out_byte_count,
  output logic [fcw_pkg::CLUSTER_W-1:0] out_cluster,
  output logic                          out_last,
  output logic [1:0]                    out_status,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcw_pkg::CFG_AW-1:0]    paddr,
  input  logic [fcw_pkg::CFG_DW-1:0]    pwdata,
  output logic [fcw_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import fcw_pkg::*;

  fcw_cfg_t    cfg;
  fcw_item_t   head;
  logic        head_valid;
  logic        pop;
  logic        res_valid;
  fcw_result_t res;

  // Geometry registers. Software must write them only while the block is idle; the
  // block does not enforce it, and the back end reads them directly without a shadow copy.
  fcw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The front end takes commands into a two-entry queue. It drops unknown commands and
  // marks a start on cluster 0 or 1 as an error item. busy is raised only when the
  // queue is full, so a new item can be taken while the back end is still stepping.
  fcw_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_command       (in_command),
    .in_fat_byte      (in_fat_byte),
    .in_start_cluster (in_start_cluster),
    .in_file_size     (in_file_size),
    .busy             (busy),
    .pop              (pop),
    .head_valid       (head_valid),
    .head             (head)
  );

  // The back end unpacks FAT bytes into the entry table, and for each chain item reads
  // the current entry, forms the image offset in a multiply stage and emits one result
  // through a registered output stage.
  fcw_back #(
    .FAT_ENTRIES (FAT_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid       = res_valid;
  assign out_byte_offset = res.byte_offset;
  assign out_byte_count  = res.byte_count;
  assign out_cluster     = res.cluster;
  assign out_last        = res.last;
  assign out_status      = res.status;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the FAT12 cluster chain walker unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcw_pkg::*;

  // Table size of the instance and the geometry constants of the FAT12 layout.
  localparam int FAT_ENTRIES        = 4096;
  localparam int TBL_AW             = $clog2(FAT_ENTRIES);
  // Only the low part of the table is loaded; every start cluster and every
  // link stays below this count so no chain reaches an entry never written.
  localparam int FILL_ENTRIES       = 256;
  localparam int ROOT_ENTRY_BYTES   = 32;
  localparam int FIRST_DATA_CLUSTER = 2;
  // One table entry is forced to point at cluster 1 so that the "next entry
  // one" path, whose offset falls below the data area, is reachable.
  localparam logic [CLUSTER_W-1:0] ONE_LINK_AT = 12'd100;
  // Cycles to let pass after the last result before touching the registers:
  // a load leaves no result but still occupies the unpack stage.
  localparam int SETTLE_CYCLES = 8;
  // Many times the slowest legal run of all items plus the register writes.
  localparam int LIMIT_CYCLES = 1000000;
  // Number of chain commands per random phase.
  localparam int PHASE_WALKS = 80;

  // One item as the testbench sees it on the command channel.
  typedef struct packed {
    logic [1:0]           command;
    logic [7:0]           fat_byte;
    logic [CLUSTER_W-1:0] start_cluster;
    logic [SIZE_W-1:0]    file_size;
  } walk_cmd_t;

  typedef enum logic [1:0] {UNPACK_LO, UNPACK_MID, UNPACK_HI} unpack_t;

  logic clk;
  logic rst_n = 1'b0;

  // Command channel.
  logic                 start            = 1'b0;
  logic                 busy;
  logic [1:0]           in_command       = CMD_NOP;
  logic [7:0]           in_fat_byte      = '0;
  logic [CLUSTER_W-1:0] in_start_cluster = '0;
  logic [SIZE_W-1:0]    in_file_size     = '0;

  // Result channel.
  logic                 out_valid;
  logic [OFFSET_W-1:0]  out_byte_offset;
  logic [COUNT_W-1:0]   out_byte_count;
  logic [CLUSTER_W-1:0] out_cluster;
  logic                 out_last;
  logic [1:0]           out_status;

  // Configuration port.
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  fat12_cluster_chain_walker_unit #(
    .FAT_ENTRIES(FAT_ENTRIES)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_fat_byte      (in_fat_byte),
    .in_start_cluster (in_start_cluster),
    .in_file_size     (in_file_size),
    .out_valid        (out_valid),
    .out_byte_offset  (out_byte_offset),
    .out_byte_count   (out_byte_count),
    .out_cluster      (out_cluster),
    .out_last         (out_last),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Items waiting for the driver, and the chain step results still owed by
  // the block, oldest first.
  walk_cmd_t   pending_cmds[$];
  fcw_result_t expected_steps[$];

  int queued_count   = 0;
  int accepted_count = 0;
  int walk_cmds      = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  int idle_left      = 0;
  int calm_left      = 0;

  // Shadow copy of the block: the FAT table as the block unpacks it, the
  // unpack state, the chain state and the geometry registers.
  logic [ENTRY_W-1:0]   fat_copy [FAT_ENTRIES];
  unpack_t              unpack_state = UNPACK_LO;
  logic [ENTRY_W-1:0]   part_entry   = '0;
  int                   fill_index   = 0;
  logic [CLUSTER_W-1:0] cur_cl       = '0;
  logic [SIZE_W-1:0]    remaining    = '0;
  bit                   chain_on     = 1'b0;

  logic [15:0] g_rsv    = 16'd1;
  logic [12:0] g_bps    = 13'd512;
  logic [7:0]  g_spc    = 8'd1;
  logic [2:0]  g_copies = 3'd2;
  logic [15:0] g_fsec   = 16'd9;
  logic [15:0] g_root   = 16'd224;

  // Entries go in strictly in order; once the table is full further entries
  // are dropped while the byte phase keeps cycling.
  function automatic void store_entry(logic [ENTRY_W-1:0] value);
    if (fill_index < FAT_ENTRIES) begin
      fat_copy[TBL_AW'(fill_index)] = value;
      fill_index++;
    end
  endfunction

  // Advances the shadow state by one item and records the result it owes.
  function automatic void predict_walk(walk_cmd_t it);
    fcw_result_t res;
    logic [ENTRY_W-1:0] link;
    longint cb;
    longint take;
    longint data_start;
    longint off;
    bit done;
    res = '0;
    case (it.command)
      CMD_LOAD: begin
        // Three raw bytes hold two 12-bit entries, low nibble first.
        case (unpack_state)
          UNPACK_LO: begin
            part_entry   = {4'h0, it.fat_byte};
            unpack_state = UNPACK_MID;
          end
          UNPACK_MID: begin
            store_entry(part_entry | {it.fat_byte[3:0], 8'h00});
            part_entry   = {8'h00, it.fat_byte[7:4]};
            unpack_state = UNPACK_HI;
          end
          default: begin
            store_entry(part_entry | {it.fat_byte, 4'h0});
            part_entry   = '0;
            unpack_state = UNPACK_LO;
          end
        endcase
      end
      CMD_START, CMD_CONT: begin
        if (it.command == CMD_START && it.start_cluster < FIRST_DATA_CLUSTER) begin
          res.status = ST_LOW_START;
          chain_on   = 1'b0;
        end else if (it.command == CMD_CONT && !chain_on) begin
          res.status = ST_NO_CHAIN;
        end else begin
          if (it.command == CMD_START) begin
            cur_cl    = it.start_cluster;
            remaining = it.file_size;
          end
          cb   = longint'(g_spc) * longint'(g_bps);
          take = cb;
          if (take > longint'(remaining)) take = longint'(remaining);
          if (take > longint'(COUNT_MAX)) take = longint'(COUNT_MAX);
          remaining  = remaining - 32'(take);
          link       = (int'(cur_cl) < FAT_ENTRIES) ? fat_copy[cur_cl] : '0;
          done       = (link == '0) || (link >= ENT_RESERVED_LO) || (remaining == '0);
          data_start = (longint'(g_rsv) + longint'(g_copies) * longint'(g_fsec))
                       * longint'(g_bps) + ROOT_ENTRY_BYTES * longint'(g_root);
          off        = data_start + (longint'(cur_cl) - FIRST_DATA_CLUSTER) * cb;
          if (off < 0) off = 0;
          if (off > longint'(32'hFFFF_FFFF)) off = longint'(32'hFFFF_FFFF);
          res.byte_offset = 32'(off);
          res.byte_count  = 20'(take);
          res.cluster     = cur_cl;
          res.last        = done;
          res.status      = ST_OK;
          if (done) begin
            chain_on = 1'b0;
          end else begin
            cur_cl   = link;
            chain_on = 1'b1;
          end
        end
        expected_steps = {expected_steps, res};
      end
      default: ;
    endcase
  endfunction

  // Fields that a command does not use carry random junk.
  function automatic walk_cmd_t random_fields();
    walk_cmd_t it;
    it.command       = CMD_NOP;
    it.fat_byte      = 8'($urandom);
    it.start_cluster = 12'($urandom);
    it.file_size     = $urandom;
    return it;
  endfunction

  function automatic void enqueue(walk_cmd_t it);
    predict_walk(it);
    pending_cmds = {pending_cmds, it};
    queued_count++;
    if (it.command == CMD_START || it.command == CMD_CONT) walk_cmds++;
  endfunction

  function automatic void queue_load(logic [7:0] b);
    walk_cmd_t it;
    it          = random_fields();
    it.command  = CMD_LOAD;
    it.fat_byte = b;
    enqueue(it);
  endfunction

  function automatic void queue_simple(logic [1:0] cmd);
    walk_cmd_t it;
    it         = random_fields();
    it.command = cmd;
    enqueue(it);
  endfunction

  // A start followed by continues for as long as the chain stays open, but
  // at most max_steps results; a cut-short chain is later restarted.
  function automatic void queue_chain(logic [CLUSTER_W-1:0] cl, logic [SIZE_W-1:0] size,
                                      int max_steps);
    walk_cmd_t it;
    int steps;
    it               = random_fields();
    it.command       = CMD_START;
    it.start_cluster = cl;
    it.file_size     = size;
    enqueue(it);
    steps = 1;
    while (chain_on && steps < max_steps) begin
      queue_simple(CMD_CONT);
      steps++;
    end
  endfunction

  // Sizes cluster around the current cluster size so that the size limit,
  // exact multiples and off-by-one remainders all come up.
  function automatic logic [SIZE_W-1:0] pick_size();
    longint cb;
    int r;
    cb = longint'(g_spc) * longint'(g_bps);
    r  = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 40) return $urandom_range(1, 32'(4 * cb));
    if (r < 55) return 32'(longint'($urandom_range(1, 6)) * cb);
    if (r < 70) return 32'(longint'($urandom_range(1, 6)) * cb + ($urandom_range(0, 1) ? 1 : -1));
    return $urandom;
  endfunction

  function automatic logic [CLUSTER_W-1:0] pick_cluster();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return CLUSTER_W'(FILL_ENTRIES - 1);
    if (r < 10) return ONE_LINK_AT;
    if (r < 13) return 12'(FIRST_DATA_CLUSTER);
    return 12'($urandom_range(FIRST_DATA_CLUSTER, FILL_ENTRIES - 1));
  endfunction

  // Table content: mostly links to loaded data clusters, with free entries,
  // end and reserved markers, and links to cluster 1.
  function automatic logic [ENTRY_W-1:0] pick_entry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return 12'($urandom_range(12'hFF7, 12'hFFF));
    if (r < 18) return 12'd1;
    return 12'($urandom_range(FIRST_DATA_CLUSTER, FILL_ENTRIES - 1));
  endfunction

  // Idle gaps between items: mostly none or short ones that land on each
  // cycle of a chain step, a few long ones, and calm stretches with no gaps.
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Random phase: mostly well-formed chains with random content, the rest
  // stray continues, low start clusters, unknown commands and extra loads.
  function automatic void queue_random_phase(int budget);
    int first;
    int r;
    walk_cmd_t it;
    first = walk_cmds;
    while (walk_cmds - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        queue_chain(pick_cluster(), pick_size(), $urandom_range(1, 16));
      end else if (r < 80) begin
        queue_simple(CMD_CONT);
      end else if (r < 86) begin
        it               = random_fields();
        it.command       = CMD_START;
        it.start_cluster = 12'($urandom_range(0, FIRST_DATA_CLUSTER - 1));
        enqueue(it);
      end else if (r < 92) begin
        queue_simple(CMD_NOP);
      end else begin
        repeat ($urandom_range(1, 3)) queue_load(8'($urandom));
      end
    end
  endfunction

  // One register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(logic [2:0] idx, logic [CFG_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes the whole geometry and mirrors it, truncated to the register
  // widths, into the shadow copy.
  task automatic set_geometry(int rsv, int bps, int spc, int copies, int fsec, int root);
    cfg_write(REG_RSV_SECT,   rsv);
    cfg_write(REG_BYTES_SECT, bps);
    cfg_write(REG_SECT_CLUS,  spc);
    cfg_write(REG_FAT_COPIES, copies);
    cfg_write(REG_FAT_SECT,   fsec);
    cfg_write(REG_ROOT_ENT,   root);
    g_rsv    = 16'(rsv);
    g_bps    = 13'(bps);
    g_spc    = 8'(spc);
    g_copies = 3'(copies);
    g_fsec   = 16'(fsec);
    g_root   = 16'(root);
  endtask

  // Waits until the driver has handed over every queued item and every owed
  // result has come back, then lets the pipeline drain.
  task automatic drain_and_settle();
    while (accepted_count != queued_count) @(posedge clk);
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: presents the next pending item once the previous one has been
  // taken (start high and busy low at the edge) and its idle gap has passed.
  always @(posedge clk) begin : drive_proc
    walk_cmd_t nxt;
    if (!rst_n) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (!start || !busy) begin
      if (start) accepted_count <= accepted_count + 1;
      if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_cmds.size() != 0) begin
        nxt               = pending_cmds.pop_front();
        in_command       <= nxt.command;
        in_fat_byte      <= nxt.fat_byte;
        in_start_cluster <= nxt.start_cluster;
        in_file_size     <= nxt.file_size;
        start            <= 1'b1;
        idle_left        <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest owed one.
  always @(posedge clk) begin : check_proc
    fcw_result_t got;
    fcw_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_byte_offset, out_byte_count, out_cluster, out_last, out_status};
      if (expected_steps.size() == 0) begin
        $display("%0t ns: unexpected result offset=%h count=%h cluster=%h last=%b status=%h",
                 $time, got.byte_offset, got.byte_count, got.cluster, got.last, got.status);
        fail_count++;
      end else begin
        want = expected_steps.pop_front();
        if (got !== want) begin
          $display("%0t ns: expected offset=%h count=%h cluster=%h last=%b status=%h", $time,
                   want.byte_offset, want.byte_count, want.cluster, want.last, want.status);
          $display("%0t ns: actual   offset=%h count=%h cluster=%h last=%b status=%h", $time,
                   got.byte_offset, got.byte_count, got.cluster, got.last, got.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog for a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus_proc
    logic [ENTRY_W-1:0] layout [FAT_ENTRIES];
    walk_cmd_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Items are generated at the falling edge so the driver never races the
    // queue fill.
    @(negedge clk);
    // Error paths that need no table: continue with no open chain, and
    // start clusters 0 and 1 with the extreme sizes.
    queue_simple(CMD_CONT);
    it = random_fields();
    it.command = CMD_START;
    it.start_cluster = 12'd0;
    it.file_size = 32'hFFFF_FFFF;
    enqueue(it);
    it.start_cluster = 12'd1;
    it.file_size = 32'h0;
    enqueue(it);
    // Unknown command with every field at all ones.
    it = '1;
    it.command = CMD_NOP;
    enqueue(it);

    // Load the low part of the table; all chains stay inside it.
    for (int e = 0; e < FILL_ENTRIES; e++) layout[TBL_AW'(e)] = pick_entry();
    layout[ONE_LINK_AT] = 12'd1;
    for (int e = 0; e < FILL_ENTRIES; e += 2) begin
      queue_load(layout[TBL_AW'(e)][7:0]);
      queue_load({layout[TBL_AW'(e + 1)][3:0], layout[TBL_AW'(e)][11:8]});
      queue_load(layout[TBL_AW'(e + 1)][11:4]);
    end

    // Directed chains under the reset geometry: highest loaded cluster with
    // the largest size, a zero-size file, the link to cluster 1, a restart
    // over an open chain and a continue after the chain has ended.
    queue_chain(CLUSTER_W'(FILL_ENTRIES - 1), 32'hFFFF_FFFF, 4);
    queue_chain(12'd2, 32'h0, 1);
    queue_chain(ONE_LINK_AT, 32'h00FF_FFFF, 3);
    queue_chain(12'd7, 32'hFFFF_FFFF, 1);
    queue_chain(12'd3, 32'd1000, 2);
    queue_chain(12'd5, 32'd1, 1);
    queue_simple(CMD_CONT);
    drain_and_settle();

    // Smallest geometry: the data area starts at zero, so cluster 1 lies
    // below it and its offset is clamped.
    set_geometry(0, 1, 1, 1, 0, 0);
    @(negedge clk);
    queue_chain(ONE_LINK_AT, 32'hFFFF_FFFF, 2);
    queue_random_phase(PHASE_WALKS);
    drain_and_settle();

    // Largest geometry within the documented ranges.
    set_geometry(65535, 4096, 128, 4, 65535, 65535);
    @(negedge clk);
    queue_chain(CLUSTER_W'(FILL_ENTRIES - 1), 32'hFFFF_FFFF, 2);
    queue_random_phase(PHASE_WALKS);
    drain_and_settle();

    // Register-width maxima: a cluster holds more than the byte count field
    // can carry, and the data area starts past 32 bits, so every offset from
    // cluster 2 up saturates while cluster 1 still lands just below it.
    set_geometry(65535, 8191, 255, 7, 65535, 65535);
    @(negedge clk);
    queue_chain(CLUSTER_W'(FILL_ENTRIES - 1), 32'hFFFF_FFFF, 2);
    queue_random_phase(PHASE_WALKS);
    drain_and_settle();

    // Two random geometries, then back to the reset values.
    repeat (2) begin
      set_geometry($urandom_range(0, 65535), $urandom_range(1, 4096), $urandom_range(1, 128),
                   $urandom_range(1, 4), $urandom_range(0, 65535), $urandom_range(0, 65535));
      @(negedge clk);
      queue_random_phase(PHASE_WALKS);
      drain_and_settle();
    end
    set_geometry(1, 512, 1, 2, 9, 224);
    @(negedge clk);
    queue_random_phase(PHASE_WALKS);
    drain_and_settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
